// ===== hdl/mhpq_pkg.sv =====
// shared types and codes for the min-heap priority queue
package mhpq_pkg;

  // width of the key and of the top key as they travel on the stream ports
  localparam int KEY_FIELD_W = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;

  // operation codes carried in the input tuser
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic rem;
  } mhpq_ctl_t;

endpackage

// ===== hdl/min_heap_priority_queue.sv =====
// top level of the min-heap priority queue: cell row, entry count and result register
//
// priority queue of up to CAPACITY unsigned keys. each input transaction carries an
// operation in in_tuser (insert, remove minimum, peek) and a key in in_tdata; each one
// gives exactly one result transaction with a status, the smallest key held after the
// operation, a flag that the queue is non-empty and the entry count. keys live in a row
// of identical cells kept in ascending order, cell 0 holding the minimum. an insert is
// broadcast to all cells at once: every cell compares its key with the new one and
// either holds, takes the new key, or takes its left neighbor's entry. a remove shifts
// the whole row one cell toward cell 0. every operation is applied to the row as its
// input is accepted, its result is registered and shown from the cycle after, and
// one transaction per clock is sustained as long as the result side keeps taking. the
// cost of this is the combinational compare across the whole row, which sets the clock.
// a remove or peek on an empty queue reports empty, an insert into a full queue is
// dropped and reports full; neither changes the contents. the result register frees
// itself for the next transaction in the same cycle that out_tready takes the current
// one. no clearing pass is needed after reset: the cell valid bits clear at once.
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_FIELD_W-1:0] in_tdata,   // [31:0] key
  input  logic [MODE_W-1:0]      in_tuser,   // [1:0] mode
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [((KEY_FIELD_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                                 out_tdata,  // [31:0] top_key, then entry_total
  output logic [STATUS_W:0]      out_tuser   // [1:0] status, [2] top_valid
);

  // stored key bits: the key field never holds more than its port width
  localparam int StoreW = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int DataW  = ((KEY_FIELD_W + CntW + 7) / 8) * 8;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  // cell row
  logic              cell_valid [CAPACITY];
  logic [StoreW-1:0] cell_key   [CAPACITY];
  logic              cell_keep  [CAPACITY];

  mhpq_ctl_t         ctl;
  logic [StoreW-1:0] new_key;

  // control and result registers
  logic                  out_valid_r, out_valid_nxt;
  logic [DataW-1:0]      out_tdata_r, out_tdata_nxt;
  logic [STATUS_W:0]     out_tuser_r, out_tuser_nxt;
  logic [CntW-1:0]       count_r, count_nxt;

  logic                  in_acc;
  logic                  is_ins, is_rem;
  logic                  empty, full;
  logic [STATUS_W-1:0]   status;
  logic [StoreW-1:0]     top_key;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign new_key   = in_tdata[StoreW-1:0];

  assign empty = (count_r == '0);
  assign full  = (count_r == CapCnt);

  // decode the operation; the spare code behaves as a peek
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    unique case (in_tuser) inside
      MODE_INSERT:            is_ins = 1'b1;
      MODE_REMOVE:            is_rem = 1'b1;
      MODE_PEEK, MODE_SPARE:  ;
      default:                ;
    endcase
  end

  // only a legal insert or remove moves the row
  assign ctl.ins = in_acc && is_ins && !full;
  assign ctl.rem = in_acc && is_rem && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic              lv, lk, rv;
      logic [StoreW-1:0] lkey, rkey;
      if (gi == 0) begin : g_head
        // the head sees a left boundary that always holds
        assign lv   = 1'b0;
        assign lkey = '0;
        assign lk   = 1'b1;
      end else begin : g_body
        assign lv   = cell_valid[gi-1];
        assign lkey = cell_key[gi-1];
        assign lk   = cell_keep[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign rv   = 1'b0;
        assign rkey = '0;
      end else begin : g_mid
        assign rv   = cell_valid[gi+1];
        assign rkey = cell_key[gi+1];
      end
      mhpq_cell #(
        .KW (StoreW)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .new_key     (new_key),
        .left_valid  (lv),
        .left_key    (lkey),
        .left_keep   (lk),
        .right_valid (rv),
        .right_key   (rkey),
        .valid       (cell_valid[gi]),
        .key         (cell_key[gi]),
        .keep        (cell_keep[gi])
      );
    end
  endgenerate

  // status and minimum as they stand once this transaction is applied
  always_comb begin
    status = STATUS_OK;
    if (is_ins && full) begin
      status = STATUS_FULL;
    end else if (!is_ins && empty) begin
      status = STATUS_EMPTY;
    end

    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.rem) begin
      count_nxt = count_r - 1'b1;
    end

    if (ctl.ins) begin
      // the head keeps its key unless the new one is smaller
      top_key = cell_keep[0] ? cell_key[0] : new_key;
    end else if (ctl.rem) begin
      top_key = (count_r > CntW'(1)) ? cell_key[1] : '0;
    end else begin
      top_key = empty ? '0 : cell_key[0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_tdata_nxt = DataW'({count_nxt, KEY_FIELD_W'(top_key)});
      out_tuser_nxt = {count_nxt != '0, status};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // count never runs past the row length
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CapCnt)
    else $error("entry count beyond capacity");

  // head cell occupancy tracks the entry count
  assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[0] == (count_r != '0))
    else $error("head cell out of step with entry count");

  // an accepted insert that fits grows the count by one
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count");

  // a result holds while the far side stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

// ===== hdl/mhpq_cell.sv =====
// one cell of the sorted key row: holds one entry and trades with its neighbors
module mhpq_cell
  import mhpq_pkg::*;
#(
  parameter int KW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mhpq_ctl_t     ctl,
  input  logic [KW-1:0] new_key,
  input  logic          left_valid,
  input  logic [KW-1:0] left_key,
  input  logic          left_keep,
  input  logic          right_valid,
  input  logic [KW-1:0] right_key,
  output logic          valid,
  output logic [KW-1:0] key,
  output logic          keep
);

  logic          valid_r, valid_nxt;
  logic [KW-1:0] key_r, key_nxt;

  // entry stays put on insert when it is not larger than the new key
  assign keep = valid_r && (key_r <= new_key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (ctl.ins) begin
      if (!keep) begin
        if (left_keep) begin
          valid_nxt = 1'b1;
          key_nxt   = new_key;
        end else begin
          valid_nxt = left_valid;
          key_nxt   = left_key;
        end
      end
    end else if (ctl.rem) begin
      valid_nxt = right_valid;
      key_nxt   = right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the min-heap priority queue: directed table, random phases, heap predictor
module tb_top;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH = 1024;
  localparam int COUNT_W    = $clog2(HEAP_DEPTH + 1);
  localparam int OUT_W      = ((KEY_FIELD_W + COUNT_W + 7) / 8) * 8;
  localparam int RUN_LIMIT  = 500000;
  localparam int SHOW_MAX   = 10;

  typedef logic [KEY_FIELD_W-1:0] key_t;

  // one result transaction, split into its fields
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    key_t                top;
    logic                valid;
    logic [COUNT_W-1:0]  total;
  } heap_result_t;

  // directed row: operation, key, and a typed-in result where fixed is set
  typedef struct packed {
    logic [MODE_W-1:0]   op;
    key_t                key;
    logic                fixed;
    logic [STATUS_W-1:0] status;
    key_t                top;
    logic                valid;
    logic [COUNT_W-1:0]  total;
  } heap_row_t;

  localparam int ROW_COUNT = 25;

  heap_row_t op_table [ROW_COUNT] = '{
    // empty queue: remove, peek and the spare code all report empty
    '{MODE_PEEK,   32'h0000_0000, 1'b1, STATUS_EMPTY, 32'h0000_0000, 1'b0, 11'd0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b1, STATUS_EMPTY, 32'h0000_0000, 1'b0, 11'd0},
    '{MODE_SPARE,  32'hFFFF_FFFF, 1'b1, STATUS_EMPTY, 32'h0000_0000, 1'b0, 11'd0},
    // single entry in and out again
    '{MODE_INSERT, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    32'hFFFF_FFFF, 1'b1, 11'd1},
    '{MODE_REMOVE, 32'h0000_0000, 1'b1, STATUS_OK,    32'h0000_0000, 1'b0, 11'd0},
    // key extremes and a duplicate minimum
    '{MODE_INSERT, 32'h8000_0000, 1'b1, STATUS_OK,    32'h8000_0000, 1'b1, 11'd1},
    '{MODE_INSERT, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    32'h8000_0000, 1'b1, 11'd2},
    '{MODE_INSERT, 32'h0000_0000, 1'b1, STATUS_OK,    32'h0000_0000, 1'b1, 11'd3},
    '{MODE_INSERT, 32'h0000_0000, 1'b1, STATUS_OK,    32'h0000_0000, 1'b1, 11'd4},
    '{MODE_INSERT, 32'h0000_0007, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_INSERT, 32'h0000_0005, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_INSERT, 32'h0000_0005, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_INSERT, 32'h5555_5555, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_INSERT, 32'hAAAA_AAAA, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_PEEK,   32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_SPARE,  32'h1234_5678, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    // drain through ties down to the last entry
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0,         1'b0, 11'd0},
    '{MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    32'h0000_0000, 1'b0, 11'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [KEY_FIELD_W-1:0] in_tdata;
  logic [MODE_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_W-1:0]       out_tdata;
  logic [STATUS_W:0]      out_tuser;

  // predictor state: heap array and entry count
  key_t        heap_keys [HEAP_DEPTH];
  int unsigned heap_count = 0;

  heap_result_t pending_results [$];

  int cycle_count  = 0;
  int fault_count  = 0;
  int result_count = 0;
  int burst_left   = 0;
  int ready_hold   = 0;
  int ready_style  = 0;
  int insert_total = 0;
  int remove_total = 0;
  int peek_total   = 0;
  int full_total   = 0;
  int empty_total  = 0;

  min_heap_priority_queue #(
    .CAPACITY  (HEAP_DEPTH),
    .KEY_WIDTH (KEY_FIELD_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // applies one operation to the heap copy and returns the state it leaves
  function automatic heap_result_t heap_apply(input logic [MODE_W-1:0] op, input key_t key);
    heap_result_t res;
    int unsigned  pos;
    int unsigned  parent;
    int unsigned  lc;
    int unsigned  rc;
    int unsigned  best;
    key_t         tmp;
    res.status = STATUS_OK;
    if (op == MODE_INSERT) begin
      insert_total++;
      if (heap_count >= HEAP_DEPTH) begin
        res.status = STATUS_FULL;
        full_total++;
      end else begin
        heap_keys[heap_count] = key;
        pos = heap_count;
        heap_count++;
        // sift up while the parent is strictly greater
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(heap_keys[parent] > heap_keys[pos])) break;
          tmp = heap_keys[parent];
          heap_keys[parent] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = parent;
        end
      end
    end else if (op == MODE_REMOVE) begin
      remove_total++;
      if (heap_count == 0) begin
        res.status = STATUS_EMPTY;
        empty_total++;
      end else begin
        heap_keys[0] = heap_keys[heap_count - 1];
        heap_count--;
        pos = 0;
        // sift down toward the smaller child, left child on a tie
        while (2 * pos + 1 < heap_count) begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          best = pos;
          if (heap_keys[pos] > heap_keys[lc]) best = lc;
          if (rc < heap_count && heap_keys[best] > heap_keys[rc]) best = rc;
          if (best == pos) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[best];
          heap_keys[best] = tmp;
          pos = best;
        end
      end
    end else begin
      // peek and the spare code leave the heap alone
      peek_total++;
      if (heap_count == 0) begin
        res.status = STATUS_EMPTY;
        empty_total++;
      end
    end
    res.valid = (heap_count > 0);
    res.top   = res.valid ? heap_keys[0] : '0;
    res.total = COUNT_W'(heap_count);
    return res;
  endfunction

  // keys lean toward extremes and a narrow range so ties are common
  function automatic key_t pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return key_t'($urandom_range(0, 31));
      5:       return 32'hFFFF_FFE0 | key_t'($urandom_range(0, 31));
      default: return key_t'($urandom);
    endcase
  endfunction

  // offers one transaction, records its expected result, then maybe idles
  task automatic offer_op(input logic [MODE_W-1:0] op, input key_t key,
                          input logic fixed, input heap_result_t typed_res);
    heap_result_t res;
    int           gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    res = heap_apply(op, key);
    pending_results.push_back(fixed ? typed_res : res);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic run_mix(input int count, input int ins_pct, input int rem_pct);
    int                roll;
    logic [MODE_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) op = MODE_INSERT;
      else if (roll < ins_pct + rem_pct) op = MODE_REMOVE;
      else op = ($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_PEEK;
      offer_op(op, pick_key(), 1'b0, '0);
    end
  endtask

  // hold the sender off until every outstanding result has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_fault(input string what, input heap_result_t want, input heap_result_t got);
    fault_count++;
    if (fault_count <= SHOW_MAX)
      $display("mismatch %0d (%s): expected status=%0d top=%h valid=%0d total=%0d,",
               fault_count, what, want.status, want.top, want.valid, want.total,
               " got status=%0d top=%h valid=%0d total=%0d",
               got.status, got.top, got.valid, got.total);
  endtask

  // result side: compare each accepted transaction with the oldest expectation
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser[STATUS_W-1:0];
      got.valid  = out_tuser[STATUS_W];
      got.top    = out_tdata[KEY_FIELD_W-1:0];
      got.total  = out_tdata[KEY_FIELD_W +: COUNT_W];
      result_count++;
      if (pending_results.size() == 0) begin
        note_fault("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_fault("field mismatch", want, got);
      end
    end
  end

  // receiver stall pattern: picks one of four ready styles at random, a new one when its hold count runs out
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_style <= $urandom_range(0, 3);
      ready_hold  <= $urandom_range(50, 300);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (cycle_count[1:0] == 2'd0);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL min_heap_priority_queue");
      $finish;
    end
  end

  initial begin
    heap_result_t typed;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= MODE_PEEK;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (op_table[i]) begin
      typed.status = op_table[i].status;
      typed.top    = op_table[i].top;
      typed.valid  = op_table[i].valid;
      typed.total  = op_table[i].total;
      offer_op(op_table[i].op, op_table[i].key, op_table[i].fixed, typed);
    end

    // hover around empty
    run_mix(250, 45, 40);
    wait_drained();

    // fill to capacity, then push against it
    while (heap_count < HEAP_DEPTH)
      offer_op(($urandom_range(0, 19) == 0) ? MODE_PEEK : MODE_INSERT, pick_key(), 1'b0, '0);
    for (int i = 0; i < 6; i++) offer_op(MODE_INSERT, pick_key(), 1'b0, '0);
    offer_op(MODE_PEEK, pick_key(), 1'b0, '0);
    offer_op(MODE_SPARE, pick_key(), 1'b0, '0);
    run_mix(120, 55, 40);
    wait_drained();

    // mostly removals from a deep heap
    run_mix(200, 20, 70);
    wait_drained();
    repeat (8) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("ran %0d inserts (%0d refused at capacity), %0d removes, %0d peeks, %0d empty hits",
             insert_total, full_total, remove_total, peek_total, empty_total);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             result_count, cycle_count, fault_count);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("PASS min_heap_priority_queue");
    end else begin
      $display("FAIL min_heap_priority_queue");
    end
    $finish;
  end

endmodule
